// File: rtl/owtr_pkg.sv
// ----------------------------------------------------------------------------
// owtr_pkg: shared types and constants of the one-wire temperature reader
// Register indexes and reset values, command codes, bus command bytes and the
// configuration bundle passed from the register file to the bus master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owtr_pkg;

  localparam int CFG_W = 20;
  localparam int IDX_W = 3;

  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [IDX_W-1:0] reg_idx_t;
  typedef logic [1:0]       cmd_t;

  // register indexes
  localparam reg_idx_t REG_RESET_LOW      = 3'd0;
  localparam reg_idx_t REG_PRESENCE_WAIT  = 3'd1;
  localparam reg_idx_t REG_RESET_RECOVERY = 3'd2;
  localparam reg_idx_t REG_SLOT_SETUP     = 3'd3;
  localparam reg_idx_t REG_SLOT_HOLD      = 3'd4;
  localparam reg_idx_t REG_READ_SAMPLE    = 3'd5;
  localparam reg_idx_t REG_CONVERT_WAIT   = 3'd6;

  // register reset values
  localparam cfg_word_t RST_RESET_LOW      = 20'd480;
  localparam cfg_word_t RST_PRESENCE_WAIT  = 20'd70;
  localparam cfg_word_t RST_RESET_RECOVERY = 20'd410;
  localparam cfg_word_t RST_SLOT_SETUP     = 20'd2;
  localparam cfg_word_t RST_SLOT_HOLD      = 20'd60;
  localparam cfg_word_t RST_READ_SAMPLE    = 20'd10;
  localparam cfg_word_t RST_CONVERT_WAIT   = 20'd750000;

  // commands
  localparam cmd_t CMD_TICK    = 2'd0;
  localparam cmd_t CMD_CONVERT = 2'd1;
  localparam cmd_t CMD_READOUT = 2'd2;

  // bus command bytes
  localparam logic [7:0] OW_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] OW_CONVERT_T    = 8'h44;
  localparam logic [7:0] OW_READ_SCRATCH = 8'hBE;

  typedef struct packed {
    cfg_word_t reset_low;
    cfg_word_t presence_wait;
    cfg_word_t reset_recovery;
    cfg_word_t slot_setup;
    cfg_word_t slot_hold;
    cfg_word_t read_sample;
    cfg_word_t convert_wait;
  } cfg_t;

endpackage

// File: rtl/one_wire_temperature_reader_top.sv
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_top: 1-Wire bus master for a temperature sensor
// Each input word is one bus tick: a command and the sampled line level. Each
// result word carries the line drive, busy/done flags and the temperature.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   item     | item_valid/item_stall | cmd, line_in
//   result   | res_valid/res_stall   | drive_low, busy_res, done_res,
//            |                       | temperature, temp_valid
//   config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One word per cycle while the result register is not stalled; a word is held in
// the input register and then appears in the result register.
// The bus state machine steps once per word as it leaves the input register.
// Reset is synchronous and restores idle state and default timings.
// A stalled result register holds its word and back-pressures the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_temperature_reader_top #(
  parameter int COUNT_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  owtr_pkg::cmd_t      cmd,
  input  logic                line_in,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                drive_low,
  output logic                busy_res,
  output logic                done_res,
  output logic signed [15:0]  temperature,
  output logic                temp_valid,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  owtr_pkg::reg_idx_t  cfg_index,
  input  owtr_pkg::cfg_word_t cfg_data
);

  localparam int EW = (COUNT_BITS + 1 > owtr_pkg::CFG_W) ? COUNT_BITS + 1 : owtr_pkg::CFG_W;
  localparam logic [EW-1:0] LIMIT = {{(EW-1){1'b0}}, 1'b1} << COUNT_BITS;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_RST_LOW   = 9'b000000010,
    PH_RST_WAIT  = 9'b000000100,
    PH_RST_RECOV = 9'b000001000,
    PH_WR_SETUP  = 9'b000010000,
    PH_WR_HOLD   = 9'b000100000,
    PH_RD_SETUP  = 9'b001000000,
    PH_RD_HOLD   = 9'b010000000,
    PH_CONV_WAIT = 9'b100000000
  } phase_t;

  function automatic logic [EW-1:0] span(input owtr_pkg::cfg_word_t r);
    logic [EW-1:0] v;
    v = EW'(r);
    if (v == '0) begin
      v = EW'(1);
    end else if (v > LIMIT) begin
      v = LIMIT;
    end
    return v;
  endfunction

  owtr_pkg::cfg_t cfg;

  owtr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data)
    , .cfg    (cfg)
  );

  assign cfg_ready = 1'b1;

  // read sample offset within the hold part, derived from the timing registers
  logic [EW-1:0] smp_ofs;
  logic [EW-1:0] setup_span, hold_span, smp_raw, smp_ofs_next;

  always_comb begin
    setup_span = span(cfg.slot_setup);
    hold_span  = span(cfg.slot_hold);
    smp_raw    = (EW'(cfg.read_sample) >= setup_span) ?
                 EW'(cfg.read_sample) - setup_span : '0;
    smp_ofs_next = (smp_raw > hold_span - EW'(1)) ? hold_span - EW'(1) : smp_raw;
  end

  always_ff @(posedge clk) begin
    smp_ofs <= smp_ofs_next;
  end

  // input register
  logic           s1_valid;
  owtr_pkg::cmd_t s1_cmd;
  logic           s1_line;
  logic           out_free, adv;

  assign out_free   = !res_valid || !res_stall;
  assign adv        = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_cmd  <= cmd;
      s1_line <= line_in;
    end
  end

  // bus state
  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [3:0]            bit_count, bit_count_next;
  logic                  byte_index, byte_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [15:0]           temp_word, temp_word_next;
  logic                  is_readout, is_readout_next;

  logic                  busy, drive, done, tvalid;
  logic [EW-1:0]         next_ext;
  logic [3:0]            bit_inc;
  logic [7:0]            sb;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    byte_index_next = byte_index;
    shift_byte_next = shift_byte;
    temp_word_next  = temp_word;
    is_readout_next = is_readout;
    busy            = (phase != PH_IDLE);
    drive           = 1'b0;
    done            = 1'b0;
    tvalid          = 1'b0;
    next_ext        = EW'(tick_count) + EW'(1);
    tick_count_next = busy ? tick_count + COUNT_BITS'(1) : tick_count;
    bit_inc         = bit_count + 4'd1;
    sb              = (EW'(tick_count) == smp_ofs) ? {s1_line, shift_byte[7:1]} : shift_byte;

    case (phase)
      PH_IDLE: begin
        if (s1_cmd == owtr_pkg::CMD_CONVERT || s1_cmd == owtr_pkg::CMD_READOUT) begin
          is_readout_next = (s1_cmd == owtr_pkg::CMD_READOUT);
          phase_next      = PH_RST_LOW;
          tick_count_next = '0;
        end
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        if (next_ext >= span(cfg.reset_low)) begin
          phase_next      = PH_RST_WAIT;
          tick_count_next = '0;
        end
      end
      PH_RST_WAIT: begin
        if (next_ext >= span(cfg.presence_wait)) begin
          // no presence pulse leaves a retry flag in the bit counter
          bit_count_next  = {3'b000, s1_line};
          phase_next      = PH_RST_RECOV;
          tick_count_next = '0;
        end
      end
      PH_RST_RECOV: begin
        if (next_ext >= span(cfg.reset_recovery)) begin
          bit_count_next  = '0;
          tick_count_next = '0;
          if (bit_count != 4'd0) begin
            phase_next = PH_RST_LOW;
          end else begin
            shift_byte_next = owtr_pkg::OW_SKIP_ROM;
            byte_index_next = 1'b0;
            phase_next      = PH_WR_SETUP;
          end
        end
      end
      PH_WR_SETUP: begin
        drive = 1'b1;
        if (next_ext >= span(cfg.slot_setup)) begin
          phase_next      = PH_WR_HOLD;
          tick_count_next = '0;
        end
      end
      PH_WR_HOLD: begin
        drive = !shift_byte[0];
        if (next_ext >= span(cfg.slot_hold)) begin
          tick_count_next = '0;
          shift_byte_next = {1'b0, shift_byte[7:1]};
          bit_count_next  = bit_inc;
          if (bit_inc < 4'd8) begin
            phase_next = PH_WR_SETUP;
          end else if (!byte_index) begin
            byte_index_next = 1'b1;
            bit_count_next  = '0;
            shift_byte_next = is_readout ? owtr_pkg::OW_READ_SCRATCH : owtr_pkg::OW_CONVERT_T;
            phase_next      = PH_WR_SETUP;
          end else begin
            bit_count_next  = '0;
            byte_index_next = 1'b0;
            shift_byte_next = '0;
            phase_next      = is_readout ? PH_RD_SETUP : PH_CONV_WAIT;
          end
        end
      end
      PH_RD_SETUP: begin
        drive = 1'b1;
        if (next_ext >= span(cfg.slot_setup)) begin
          phase_next      = PH_RD_HOLD;
          tick_count_next = '0;
        end
      end
      PH_RD_HOLD: begin
        shift_byte_next = sb;
        if (next_ext >= span(cfg.slot_hold)) begin
          tick_count_next = '0;
          bit_count_next  = bit_inc;
          if (bit_inc < 4'd8) begin
            phase_next = PH_RD_SETUP;
          end else if (!byte_index) begin
            temp_word_next  = {8'h00, sb};
            byte_index_next = 1'b1;
            bit_count_next  = '0;
            phase_next      = PH_RD_SETUP;
          end else begin
            temp_word_next  = {sb, temp_word[7:0]};
            bit_count_next  = '0;
            byte_index_next = 1'b0;
            done            = 1'b1;
            tvalid          = 1'b1;
            phase_next      = PH_IDLE;
          end
        end
      end
      PH_CONV_WAIT: begin
        if (next_ext >= span(cfg.convert_wait)) begin
          done            = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_count  <= '0;
      byte_index <= 1'b0;
      shift_byte <= '0;
      temp_word  <= '0;
      is_readout <= 1'b0;
    end else if (adv) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      byte_index <= byte_index_next;
      shift_byte <= shift_byte_next;
      temp_word  <= temp_word_next;
      is_readout <= is_readout_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_low   <= drive;
      busy_res    <= busy;
      done_res    <= done;
      temperature <= temp_word_next;
      temp_valid  <= tvalid;
    end
  end

  // a readout result only comes with completion
  a_valid_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && temp_valid |-> done_res)
    else $error("temp_valid without done_res");

  // completion only at the end of a transaction in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> busy_res)
    else $error("done_res outside a transaction");

  // no word may appear in the result register without one in the input register
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !s1_valid && !res_stall |=> !res_valid)
    else $error("result word without input word");

  // the tick counter rests at zero while idle
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("tick counter not cleared in idle");

endmodule

// File: rtl/owtr_cfg.sv
// ----------------------------------------------------------------------------
// owtr_cfg: timing register file
// Seven 20-bit timing registers, loaded with their defaults at reset and
// written one word at a time; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owtr_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  owtr_pkg::reg_idx_t  wr_index,
  input  owtr_pkg::cfg_word_t wr_data,
  output owtr_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low      <= owtr_pkg::RST_RESET_LOW;
      cfg.presence_wait  <= owtr_pkg::RST_PRESENCE_WAIT;
      cfg.reset_recovery <= owtr_pkg::RST_RESET_RECOVERY;
      cfg.slot_setup     <= owtr_pkg::RST_SLOT_SETUP;
      cfg.slot_hold      <= owtr_pkg::RST_SLOT_HOLD;
      cfg.read_sample    <= owtr_pkg::RST_READ_SAMPLE;
      cfg.convert_wait   <= owtr_pkg::RST_CONVERT_WAIT;
    end else if (wr_en) begin
      case (wr_index)
        owtr_pkg::REG_RESET_LOW:      cfg.reset_low      <= wr_data;
        owtr_pkg::REG_PRESENCE_WAIT:  cfg.presence_wait  <= wr_data;
        owtr_pkg::REG_RESET_RECOVERY: cfg.reset_recovery <= wr_data;
        owtr_pkg::REG_SLOT_SETUP:     cfg.slot_setup     <= wr_data;
        owtr_pkg::REG_SLOT_HOLD:      cfg.slot_hold      <= wr_data;
        owtr_pkg::REG_READ_SAMPLE:    cfg.read_sample    <= wr_data;
        owtr_pkg::REG_CONVERT_WAIT:   cfg.convert_wait   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule
